@@ hw/rtl/nsdf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package nsdf_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	localparam int ADDR_W = 16;
	localparam int SEQ_W = 16;
	localparam int STATUS_W = 2;

	localparam logic [SEQ_W-1:0] WINDOW_RESET = 16'd100;

	localparam logic [STATUS_W-1:0] ST_UPDATED   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ADDED     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

	typedef struct packed {
		logic load;
		logic rd_en;
		logic finish;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic more;
		logic hit;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/nsdf_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface nsdf_pkt_if;
	logic                        valid;
	logic                        ready;
	logic [nsdf_pkg::ADDR_W-1:0] sender_address;
	logic [nsdf_pkg::SEQ_W-1:0]  sequence_number;

	modport source (output valid, output sender_address, output sequence_number, input ready);
	modport sink (input valid, input sender_address, input sequence_number, output ready);
endinterface

interface nsdf_res_if;
	logic                          valid;
	logic                          ready;
	logic                          accept;
	logic [nsdf_pkg::STATUS_W-1:0] status;

	modport source (output valid, output accept, output status, input ready);
	modport sink (input valid, input accept, input status, output ready);
endinterface

interface nsdf_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [nsdf_pkg::SEQ_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/nsdf_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module nsdf_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  pkt_valid,
	output logic                 pkt_ready,
	input  wire nsdf_pkg::sts_t  sts,
	output nsdf_pkg::cmd_t       cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d   = state_q;
		pkt_ready = 1'b0;
		cmd       = '0;
		unique case (state_q)
			S_IDLE: begin
				pkt_ready = 1'b1;
				if (pkt_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.hit || !sts.more) begin
					cmd.finish = 1'b1;
					state_d    = S_DONE;
				end else begin
					cmd.rd_en = 1'b1;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/nsdf_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module nsdf_datapath (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire nsdf_pkg::cmd_t           cmd,
	output nsdf_pkg::sts_t                sts,
	input  wire [nsdf_pkg::ADDR_W-1:0]    sender_address,
	input  wire [nsdf_pkg::SEQ_W-1:0]     sequence_number,
	input  wire                           cfg_wr,
	input  wire [nsdf_pkg::SEQ_W-1:0]     cfg_data,
	output logic                          out_valid,
	input  wire                           out_ready,
	output logic                          out_accept,
	output logic [nsdf_pkg::STATUS_W-1:0] out_status
);

	localparam int ENT_W = nsdf_pkg::ADDR_W + nsdf_pkg::SEQ_W;

	logic [ENT_W-1:0] mem [nsdf_pkg::TABLE_ENTRIES];

	logic [nsdf_pkg::SEQ_W-1:0]    window_q;
	logic [nsdf_pkg::CNT_W-1:0]    count_q;
	logic [nsdf_pkg::CNT_W-1:0]    scan_idx_q;
	logic [nsdf_pkg::ADDR_W-1:0]   addr_q;
	logic [nsdf_pkg::SEQ_W-1:0]    seq_q;
	logic                          rd_vld_s1;
	logic [nsdf_pkg::IDX_W-1:0]    rd_idx_s1;
	logic [ENT_W-1:0]              rd_data_s1;
	logic                          res_accept_q;
	logic [nsdf_pkg::STATUS_W-1:0] res_status_q;
	logic                          out_valid_q;

	logic [nsdf_pkg::ADDR_W-1:0]   ent_addr;
	logic [nsdf_pkg::SEQ_W-1:0]    ent_last;
	logic [nsdf_pkg::SEQ_W-1:0]    floor_seq;
	logic [nsdf_pkg::SEQ_W-1:0]    diff_last;
	logic [nsdf_pkg::SEQ_W-1:0]    diff_floor;
	logic                          after_last;
	logic                          after_floor;
	logic                          dup;
	logic                          hit;
	logic                          room;
	logic                          wr_en;
	logic [nsdf_pkg::IDX_W-1:0]    wr_idx;
	logic                          res_accept_d;
	logic [nsdf_pkg::STATUS_W-1:0] res_status_d;

	assign ent_addr    = rd_data_s1[ENT_W-1:nsdf_pkg::SEQ_W];
	assign ent_last    = rd_data_s1[nsdf_pkg::SEQ_W-1:0];
	assign floor_seq   = ent_last - window_q;
	assign diff_last   = seq_q - ent_last;
	assign diff_floor  = seq_q - floor_seq;
	assign after_last  = (diff_last != '0) && !diff_last[nsdf_pkg::SEQ_W-1];
	assign after_floor = (diff_floor != '0) && !diff_floor[nsdf_pkg::SEQ_W-1];
	assign dup         = !after_last && after_floor;
	assign hit         = rd_vld_s1 && (ent_addr == addr_q);
	assign room        = (count_q < nsdf_pkg::CNT_W'(nsdf_pkg::TABLE_ENTRIES));

	assign sts.more     = (scan_idx_q < count_q);
	assign sts.hit      = hit;
	assign sts.out_free = !out_valid_q || out_ready;

	always_comb begin
		wr_en        = 1'b0;
		wr_idx       = count_q[nsdf_pkg::IDX_W-1:0];
		res_accept_d = 1'b0;
		res_status_d = nsdf_pkg::ST_FULL;
		if (hit) begin
			wr_idx = rd_idx_s1;
			if (dup) begin
				res_status_d = nsdf_pkg::ST_DUPLICATE;
			end else begin
				wr_en        = cmd.finish;
				res_accept_d = 1'b1;
				res_status_d = nsdf_pkg::ST_UPDATED;
			end
		end else if (room) begin
			wr_en        = cmd.finish;
			res_accept_d = 1'b1;
			res_status_d = nsdf_pkg::ST_ADDED;
		end
	end

	// table storage, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= {addr_q, seq_q};
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= mem[scan_idx_q[nsdf_pkg::IDX_W-1:0]];
			rd_idx_s1  <= scan_idx_q[nsdf_pkg::IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q <= sender_address;
			seq_q  <= sequence_number;
		end
		if (cmd.finish) begin
			res_accept_q <= res_accept_d;
			res_status_q <= res_status_d;
		end
		if (cmd.emit) begin
			out_accept <= res_accept_q;
			out_status <= res_status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= nsdf_pkg::WINDOW_RESET;
			count_q     <= '0;
			scan_idx_q  <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				window_q <= cfg_data;
			end
			if (cmd.finish && !hit && room) begin
				count_q <= count_q + nsdf_pkg::CNT_W'(1);
			end
			if (cmd.load) begin
				scan_idx_q <= '0;
			end else if (cmd.rd_en) begin
				scan_idx_q <= scan_idx_q + nsdf_pkg::CNT_W'(1);
			end
			rd_vld_s1 <= cmd.rd_en;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

@@ hw/rtl/neighbor_seqnum_duplicate_filter.sv @@
// neighbor_seqnum_duplicate_filter
// pkt: one beat per received packet (sender_address, sequence_number).
// res: one beat per packet, accept plus status (updated, added, duplicate,
//      table full), delivered in packet order.
// cfg: one beat writes window_offset; always ready, write only while idle.
// a packet is taken only when the block is idle; the 16-entry sender table
// is read one entry per cycle through its single registered read port, in
// insertion order, until the sender is found or every entry has been read;
// the result is then registered, and the block is idle again once it has
// moved to the output register, so no new packet is taken before the last
// one is through the scan.
// a result waits in the output register while res is stalled; the next
// packet is accepted meanwhile and its result is held until the output
// register frees.
// reset clears the entry count (table empty), restores window_offset to
// 100 and drops any pending result; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module neighbor_seqnum_duplicate_filter (
	input  wire         clk,
	input  wire         arst_n,
	nsdf_pkt_if.sink    pkt,
	nsdf_res_if.source  res,
	nsdf_cfg_if.sink    cfg
);

	nsdf_pkg::cmd_t cmd;
	nsdf_pkg::sts_t sts;

	assign cfg.ready = 1'b1;

	nsdf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt.valid),
		.pkt_ready (pkt.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	nsdf_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.sender_address  (pkt.sender_address),
		.sequence_number (pkt.sequence_number),
		.cfg_wr          (cfg.valid && cfg.ready),
		.cfg_data        (cfg.data),
		.out_valid       (res.valid),
		.out_ready       (res.ready),
		.out_accept      (res.accept),
		.out_status      (res.status)
	);

`ifndef ASSERT_OFF
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.rd_en, cmd.finish, cmd.emit}))
		else $error("more than one command at once");

	a_busy_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		(pkt.valid && pkt.ready) |=> !pkt.ready)
		else $error("packet accepted while busy");

	a_finish_holds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> !pkt.ready && !cmd.rd_en)
		else $error("scan continued after finish");

	a_accept_status: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.accept) |->
		(res.status == nsdf_pkg::ST_UPDATED || res.status == nsdf_pkg::ST_ADDED))
		else $error("accept with a drop status");
`endif

endmodule

`default_nettype wire
